// ----- src/gob_pkg.sv -----
`default_nettype none

package gob_pkg;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int MAG_W  = 31;

  localparam logic [31:0]      TAN_LOW_Q30  = 32'd444758426;
  localparam logic [31:0]      TAN_HIGH_Q30 = 32'd2592242074;
  localparam logic [MAG_W-1:0] DX_OFFSET    = 31'd7;
  localparam logic [MAG_W-1:0] SAT_POS      = 31'h7FFF_FFFF;

  localparam logic [2:0] BIN_VERTICAL = 3'd4;

  typedef logic [2:0] bin_t;

endpackage

`default_nettype wire

// ----- src/gob_sqrt_pipe.sv -----
`default_nettype none

module gob_sqrt_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [gob_pkg::RAD_W-1:0]   radicand,
  input  wire gob_pkg::bin_t               in_bin,
  output logic                             res_valid,
  output logic      [gob_pkg::ROOT_W-1:0]  root,
  output gob_pkg::bin_t                    res_bin
);
  import gob_pkg::*;

  logic              st_valid [ROOT_W];
  logic [RAD_W-1:0]  st_rad   [ROOT_W];
  logic [REM_W-1:0]  st_rem   [ROOT_W];
  logic [ROOT_W-1:0] st_root  [ROOT_W];
  bin_t              st_bin   [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              prev_valid;
    logic [RAD_W-1:0]  prev_rad;
    logic [REM_W-1:0]  prev_rem;
    logic [ROOT_W-1:0] prev_root;
    bin_t              prev_bin;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (i == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_rad   = radicand;
      assign prev_rem   = '0;
      assign prev_root  = '0;
      assign prev_bin   = in_bin;
    end else begin : g_next
      assign prev_valid = st_valid[i-1];
      assign prev_rad   = st_rad[i-1];
      assign prev_rem   = st_rem[i-1];
      assign prev_root  = st_root[i-1];
      assign prev_bin   = st_bin[i-1];
    end

    // one result bit per stage, restoring
    assign cur   = {prev_rem, prev_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, prev_root, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i] <= 1'b0;
      end else if (en) begin
        st_valid[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rad[i]  <= {prev_rad[RAD_W-3:0], 2'b00};
        st_rem[i]  <= take ? REM_W'(cur - trial) : cur[REM_W-1:0];
        st_root[i] <= {prev_root[ROOT_W-2:0], take};
        st_bin[i]  <= prev_bin;
      end
    end
  end

  assign res_valid = st_valid[ROOT_W-1];
  assign root      = st_root[ROOT_W-1];
  assign res_bin   = st_bin[ROOT_W-1];

endmodule

`default_nettype wire

// ----- src/gradient_orientation_binner.sv -----
// Gradient orientation binner, eight HOG orientation bins.
// Input channel (in_valid/in_ready): four neighbour gamma values (Q20.4) and
// a border flag per pixel. Output channel (out_valid/out_ready): the bin and
// the gradient magnitude (Q16.16) of that pixel, one result per pixel, in
// order. Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
// inverse deviation (Q12.20); cfg_ready is always high, write only when idle.
// Throughput: one pixel per cycle while in_ready is high. A result passes
// five arithmetic stages (differences, scale, saturate and fold, constant
// multiplies and squares, threshold compares), a 32-stage square root, one
// root bit per stage, and the output register before it shows on out_valid.
// When the receiver stalls, one more result lands in a skid register and
// in_ready drops; the pipeline then holds, nothing lost or repeated.
// Reset clears all valid bits and loads the inverse deviation with 1.0.
// Border pixels give bin 0 and magnitude 0.
`default_nettype none

module gradient_orientation_binner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] above_value,
  input  wire logic [23:0] below_value,
  input  wire logic [23:0] left_value,
  input  wire logic [23:0] right_value,
  input  wire logic        on_border,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       orientation_bin,
  output logic [31:0]      magnitude
);
  import gob_pkg::*;

  logic [31:0] inverse_deviation;
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_deviation <= 32'd1048576;
    end else if (cfg_valid && cfg_ready) begin
      inverse_deviation <= cfg_data;
    end
  end

  // stage 1: absolute differences
  logic        s1_valid, s1_border, s1_dy_neg, s1_dx_neg;
  logic [23:0] s1_dy_abs, s1_dx_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_border <= on_border;
      s1_dy_neg <= below_value < above_value;
      s1_dy_abs <= (below_value < above_value) ? above_value - below_value
                                               : below_value - above_value;
      s1_dx_neg <= right_value < left_value;
      s1_dx_abs <= (right_value < left_value) ? left_value - right_value
                                              : right_value - left_value;
    end
  end

  // stage 2: scale by inverse deviation
  logic        s2_valid, s2_border, s2_dy_neg, s2_dx_neg;
  logic [55:0] s2_py, s2_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_border <= s1_border;
      s2_dy_neg <= s1_dy_neg;
      s2_dx_neg <= s1_dx_neg;
      s2_py     <= 56'(s1_dy_abs) * 56'(inverse_deviation);
      s2_px     <= 56'(s1_dx_abs) * 56'(inverse_deviation);
    end
  end

  // stage 3: Q15.16 saturation, dx offset, fold into right half-plane
  logic [MAG_W-1:0] py, px, ax_next;
  logic [31:0]      dx_sum;
  logic             flip;

  always_comb begin
    py = (|s2_py[55:39]) ? SAT_POS : s2_py[38:8];
    px = (|s2_px[55:39]) ? SAT_POS : s2_px[38:8];
    dx_sum = {1'b0, px} + {1'b0, DX_OFFSET};
    flip = 1'b0;
    if (!s2_dx_neg) begin
      ax_next = dx_sum[31] ? SAT_POS : dx_sum[MAG_W-1:0];
    end else if (px > DX_OFFSET) begin
      ax_next = px - DX_OFFSET;
      flip    = 1'b1;
    end else begin
      ax_next = DX_OFFSET - px;
    end
  end

  logic             s3_valid, s3_border, s3_ay_neg;
  logic [MAG_W-1:0] s3_ax, s3_ay_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_border <= s2_border;
      s3_ax     <= ax_next;
      s3_ay_abs <= py;
      s3_ay_neg <= (s2_dy_neg ^ flip) && (py != '0);
    end
  end

  // stage 4: threshold products and squares
  logic             s4_valid, s4_border, s4_ay_neg, s4_ax_zero, s4_mid_ge, s4_mid_le;
  logic [MAG_W-1:0] s4_ay_abs;
  logic [62:0]      s4_e1, s4_e3;
  logic [61:0]      s4_sqx, s4_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_border  <= s3_border;
      s4_ay_neg  <= s3_ay_neg;
      s4_ay_abs  <= s3_ay_abs;
      s4_ax_zero <= s3_ax == '0;
      s4_mid_ge  <= s3_ay_abs >= s3_ax;
      s4_mid_le  <= s3_ay_abs <= s3_ax;
      s4_e1      <= 63'(s3_ax) * 63'(TAN_LOW_Q30);
      s4_e3      <= 63'(s3_ax) * 63'(TAN_HIGH_Q30);
      s4_sqx     <= 62'(s3_ax) * 62'(s3_ax);
      s4_sqy     <= 62'(s3_ay_abs) * 62'(s3_ay_abs);
    end
  end

  // stage 5: sector count and radicand
  logic [62:0] ayq;
  logic [2:0]  k;
  bin_t        bin_next;

  always_comb begin
    ayq = {2'b00, s4_ay_abs, 30'd0};
    if (s4_ay_neg) begin
      k = 3'(ayq <= s4_e3) + 3'(s4_mid_le) + 3'(ayq <= s4_e1);
    end else begin
      k = 3'd4 + 3'(ayq >= s4_e1) + 3'(s4_mid_ge) + 3'(ayq >= s4_e3);
    end
    priority if (s4_border) begin
      bin_next = '0;
    end else if (s4_ax_zero && !s4_ay_neg && s4_ay_abs != '0) begin
      bin_next = BIN_VERTICAL;
    end else begin
      bin_next = k + 3'd4;
    end
  end

  logic             s5_valid;
  bin_t             s5_bin;
  logic [RAD_W-1:0] s5_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_bin <= bin_next;
      s5_rad <= s4_border ? '0 : RAD_W'(s4_sqx) + RAD_W'(s4_sqy);
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  bin_t              sq_bin;

  gob_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .radicand  (s5_rad),
    .in_bin    (s5_bin),
    .res_valid (sq_valid),
    .root      (sq_root),
    .res_bin   (sq_bin)
  );

  // output register with skid
  logic              skid_valid;
  bin_t              skid_bin;
  logic [ROOT_W-1:0] skid_mag;
  logic              transfer, out_free;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign transfer = en && sq_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || transfer;
      skid_valid <= 1'b0;
    end else if (transfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        orientation_bin <= skid_bin;
        magnitude       <= skid_mag;
      end else if (transfer) begin
        orientation_bin <= sq_bin;
        magnitude       <= sq_root;
      end
    end else if (transfer) begin
      skid_bin <= sq_bin;
      skid_mag <= sq_root;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !out_ready) |=> (skid_valid && $stable(skid_mag)))
    else $error("skid result lost while output stalled");

  a_no_neg_zero: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ay_neg) |-> (s3_ay_abs != '0))
    else $error("negative sign on zero dy");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (en && s4_valid && s4_border) |=> (s5_valid && s5_bin == '0 && s5_rad == '0))
    else $error("border pixel not forced to zero");
`endif

endmodule

`default_nettype wire
